// ----- hdl/register_write_command_parser_assert.svh -----
// Assertion macros used by the checker file of the command parser.
`ifndef REGISTER_WRITE_COMMAND_PARSER_ASSERT_SVH
`define REGISTER_WRITE_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RWCP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rwcp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RWCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rwcp assertion failed");

`endif

// ----- hdl/rwcp_pkg.sv -----
// Shared types and constants of the register write command parser.
package rwcp_pkg;

	// Width of a parsed number field
	localparam int VALUE_WIDTH = 16;

	// Depth of the token queue between front and back (power of two)
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Characters with a meaning of their own
	localparam logic [7:0] CH_END   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_X     = 8'h78;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_USAGE   = 2'd1;
	localparam logic [1:0] ST_NAN     = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	// Character classes produced by the front
	typedef enum logic [2:0] {
		TK_END,
		TK_SPACE,
		TK_X,
		TK_DIGIT,
		TK_HEX,
		TK_OTHER
	} tok_kind_t;

	// One classified character
	typedef struct packed {
		tok_kind_t   kind;
		logic [3:0]  digit;
		logic [7:0]  ch;
	} token_t;

	// Line parse phase
	typedef enum logic [2:0] {
		PH_LETTER,
		PH_SEP,
		PH_FIRST,
		PH_ADDR,
		PH_VALUE,
		PH_IGNORE
	} phase_t;

endpackage

// ----- hdl/rwcp_channels.sv -----
// Valid/ready channel interfaces for characters in and results out.
interface rwcp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface rwcp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] write_address;
	logic [15:0] write_data;
	logic [7:0]  bad_char;

	modport source (output valid, output status, output write_address, output write_data,
		output bad_char, input ready);
	modport sink (input valid, input status, input write_address, input write_data,
		input bad_char, output ready);
endinterface

// ----- hdl/rwcp_front.sv -----
// Front stage: accepts characters and classifies them into tokens.
module rwcp_front (
	input  logic            clk,
	input  logic            arst_n,
	rwcp_char_if.sink       char_in,
	output logic            tok_valid,
	output rwcp_pkg::token_t tok,
	input  logic            tok_ready
);
	import rwcp_pkg::*;

	logic   tok_valid_s1;
	token_t tok_s1;
	token_t cls;
	logic   take;

	// Character classification
	always_comb begin
		cls.ch = char_in.ch;
		cls.digit = 4'd0;
		if (char_in.ch == CH_END) begin
			cls.kind = TK_END;
		end else if (char_in.ch == CH_SPACE) begin
			cls.kind = TK_SPACE;
		end else if (char_in.ch == CH_X) begin
			cls.kind = TK_X;
		end else if (char_in.ch >= "0" && char_in.ch <= "9") begin
			cls.kind = TK_DIGIT;
			cls.digit = 4'(char_in.ch - 8'("0"));
		end else if (char_in.ch >= "a" && char_in.ch <= "f") begin
			cls.kind = TK_HEX;
			cls.digit = 4'(char_in.ch - 8'("a") + 8'd10);
		end else if (char_in.ch >= "A" && char_in.ch <= "F") begin
			cls.kind = TK_HEX;
			cls.digit = 4'(char_in.ch - 8'("A") + 8'd10);
		end else begin
			cls.kind = TK_OTHER;
		end
	end

	// Stage register frees up when the queue takes its token
	assign char_in.ready = !tok_valid_s1 || tok_ready;
	assign take = char_in.valid && char_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s1 <= 1'b0;
		end else if (take) begin
			tok_valid_s1 <= 1'b1;
		end else if (tok_ready) begin
			tok_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_s1 <= cls;
		end
	end

	assign tok_valid = tok_valid_s1;
	assign tok = tok_s1;
endmodule

// ----- hdl/rwcp_queue.sv -----
// Short token queue between front and back.
module rwcp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  rwcp_pkg::token_t push_tok,
	output logic             push_ready,
	output logic             pop_valid,
	output rwcp_pkg::token_t pop_tok,
	input  logic             pop_ready
);
	import rwcp_pkg::*;

	token_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;
	assign pop_tok = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end
endmodule

// ----- hdl/rwcp_back.sv -----
// Back end: line parser state machine and result output register.
module rwcp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_valid,
	input  rwcp_pkg::token_t tok,
	output logic             tok_ready,
	rwcp_result_if.source    result_out
);
	import rwcp_pkg::*;

	// Line state
	phase_t                 phase_q, phase_d;
	logic                   hex_q, hex_d;
	logic [VALUE_WIDTH-1:0] acc_q, acc_d;
	logic [VALUE_WIDTH-1:0] addr_q, addr_d;
	logic [1:0]             err_q, err_d;
	logic [7:0]             errch_q, errch_d;

	// Result register
	logic                   res_valid_q;
	logic [1:0]             res_status_q;
	logic [VALUE_WIDTH-1:0] res_addr_q;
	logic [VALUE_WIDTH-1:0] res_data_q;
	logic [7:0]             res_bad_q;

	logic                   pop;
	logic                   is_end;
	logic                   dig_ok;
	logic [VALUE_WIDTH-1:0] acc_step;
	logic [1:0]             res_status;
	logic [VALUE_WIDTH-1:0] res_addr;
	logic [VALUE_WIDTH-1:0] res_data;
	logic [7:0]             res_bad;

	// Digit accumulate: shift by four in hex, times ten in decimal
	assign dig_ok = (tok.kind == TK_DIGIT) || (tok.kind == TK_HEX && hex_q);
	always_comb begin
		if (hex_q) begin
			acc_step = {acc_q[VALUE_WIDTH-5:0], tok.digit};
		end else begin
			acc_step = (acc_q << 3) + (acc_q << 1) + VALUE_WIDTH'(tok.digit);
		end
	end

	// Next state
	always_comb begin
		phase_d = phase_q;
		hex_d   = hex_q;
		acc_d   = acc_q;
		addr_d  = addr_q;
		err_d   = err_q;
		errch_d = errch_q;
		if (pop) begin
			if (is_end) begin
				phase_d = PH_LETTER;
				hex_d   = 1'b0;
				acc_d   = '0;
				addr_d  = '0;
				err_d   = ST_OK;
				errch_d = 8'd0;
			end else begin
				unique case (phase_q)
					PH_LETTER: begin
						phase_d = PH_SEP;
					end
					PH_SEP: begin
						if (tok.kind == TK_SPACE) begin
							phase_d = PH_FIRST;
						end else begin
							err_d   = ST_USAGE;
							phase_d = PH_IGNORE;
						end
					end
					PH_FIRST, PH_ADDR, PH_VALUE: begin
						if (phase_q != PH_VALUE) begin
							phase_d = PH_ADDR;
						end
						if (tok.kind == TK_SPACE) begin
							if (phase_q == PH_VALUE) begin
								phase_d = PH_IGNORE;
							end else begin
								addr_d  = acc_q;
								acc_d   = '0;
								hex_d   = 1'b0;
								phase_d = PH_VALUE;
							end
						end else if (tok.kind == TK_X) begin
							hex_d = 1'b1;
						end else if (dig_ok) begin
							acc_d = acc_step;
						end else begin
							err_d   = ST_NAN;
							errch_d = tok.ch;
							phase_d = PH_IGNORE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Outputs: pop control and the result of a finished line
	always_comb begin
		is_end = (tok.kind == TK_END);
		pop = tok_valid && (!is_end || !res_valid_q || result_out.ready);
		tok_ready = pop;
		res_addr = '0;
		res_data = '0;
		res_bad = 8'd0;
		if (err_q != ST_OK) begin
			res_status = err_q;
			if (err_q == ST_NAN) begin
				res_bad = errch_q;
			end
		end else if (phase_q == PH_LETTER || phase_q == PH_SEP || phase_q == PH_FIRST) begin
			res_status = ST_USAGE;
		end else if (phase_q == PH_ADDR) begin
			res_status = ST_MISSING;
		end else begin
			res_status = ST_OK;
			res_addr = addr_q;
			res_data = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LETTER;
			hex_q       <= 1'b0;
			acc_q       <= '0;
			addr_q      <= '0;
			err_q       <= ST_OK;
			errch_q     <= 8'd0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			hex_q   <= hex_d;
			acc_q   <= acc_d;
			addr_q  <= addr_d;
			err_q   <= err_d;
			errch_q <= errch_d;
			if (pop && is_end) begin
				res_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop && is_end) begin
			res_status_q <= res_status;
			res_addr_q   <= res_addr;
			res_data_q   <= res_data;
			res_bad_q    <= res_bad;
		end
	end

	assign result_out.valid         = res_valid_q;
	assign result_out.status        = res_status_q;
	assign result_out.write_address = res_addr_q;
	assign result_out.write_data    = res_data_q;
	assign result_out.bad_char      = res_bad_q;
endmodule

// ----- hdl/register_write_command_parser.sv -----
// A line's result is registered on result_out once its zero byte has passed the front stage and the queue.
// Throughput: one character per cycle while the queue has room; the parser consumes one queued token each cycle.
// A result waiting on result_out stalls only the zero byte of the next line, via the queue.
// Reset (arst_n low, asynchronous) empties the queue and returns to the start of a line.
// Top level: character front stage, token queue and line parser back end.
module register_write_command_parser (
	input  logic          clk,
	input  logic          arst_n,
	rwcp_char_if.sink     char_in,
	rwcp_result_if.source result_out
);
	import rwcp_pkg::*;

	logic   front_valid;
	token_t front_tok;
	logic   front_ready;
	logic   back_valid;
	token_t back_tok;
	logic   back_ready;

	rwcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_in),
		.tok_valid (front_valid),
		.tok       (front_tok),
		.tok_ready (front_ready)
	);

	rwcp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_tok   (front_tok),
		.push_ready (front_ready),
		.pop_valid  (back_valid),
		.pop_tok    (back_tok),
		.pop_ready  (back_ready)
	);

	rwcp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (back_valid),
		.tok        (back_tok),
		.tok_ready  (back_ready),
		.result_out (result_out)
	);
endmodule

// ----- hdl/rwcp_checker.sv -----
// Port-level checks on the command parser results, bound to the top level.
`include "register_write_command_parser_assert.svh"

module rwcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [15:0] write_address,
	input logic [15:0] write_data,
	input logic [7:0]  bad_char
);
	import rwcp_pkg::*;

	// A stalled result holds
	`RWCP_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(write_address) && $stable(write_data) && $stable(bad_char))
	// Only a not-a-number error reports a character
	`RWCP_ASSERT_IMPL(a_bad_char, clk, arst_n, out_valid && status != ST_NAN, bad_char == 8'd0)
	// Errors carry no write
	`RWCP_ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && status != ST_OK, write_address == 16'd0 && write_data == 16'd0)
	// Not a number always names a non-zero character
	`RWCP_ASSERT_IMPL(a_nan_char, clk, arst_n, out_valid && status == ST_NAN, bad_char != 8'd0)
endmodule

bind register_write_command_parser rwcp_checker u_rwcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result_out.valid),
	.out_ready     (result_out.ready),
	.status        (result_out.status),
	.write_address (result_out.write_address),
	.write_data    (result_out.write_data),
	.bad_char      (result_out.bad_char)
);

// ----- dv/testbench.sv -----
// Self-checking testbench for the register write command parser.
module testbench;
	import rwcp_pkg::*;

	localparam int CHAR_TARGET = 1350;
	localparam int IDLE_LIMIT  = 2000;

	typedef struct packed {
		logic [1:0]             status;
		logic [VALUE_WIDTH-1:0] write_address;
		logic [VALUE_WIDTH-1:0] write_data;
		logic [7:0]             bad_char;
	} line_result_t;

	logic clk = 1'b0;
	logic arst_n;

	rwcp_char_if   char_in();
	rwcp_result_if result_out();

	register_write_command_parser uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.result_out (result_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Characters waiting to be sent, line being built, results still owed
	logic [7:0]   pending_chars[$];
	logic [7:0]   line_buf[$];
	line_result_t expected_results[$];

	int error_count     = 0;
	int lines_sent      = 0;
	int chars_accepted  = 0;
	int results_checked = 0;
	int writes_checked  = 0;
	int idle_cycles     = 0;

	// Parser state as the predictor sees it
	phase_t                 line_phase;
	logic                   hex_seen;
	logic [VALUE_WIDTH-1:0] field_acc;
	logic [VALUE_WIDTH-1:0] addr_hold;
	logic [1:0]             line_err;
	logic [7:0]             line_err_char;

	function automatic void clear_line();
		line_phase    = PH_LETTER;
		hex_seen      = 1'b0;
		field_acc     = '0;
		addr_hold     = '0;
		line_err      = ST_OK;
		line_err_char = '0;
	endfunction

	// One character of an address or value field
	function automatic void take_digit(input logic [7:0] c);
		logic [4:0] d;
		d = '0;
		if (c == CH_X) begin
			hex_seen = 1'b1;
			return;
		end
		if (c >= "0" && c <= "9") begin
			d = 5'(c - "0");
		end else if (hex_seen && c >= "a" && c <= "f") begin
			d = 5'(c - "a" + 8'd10);
		end else if (hex_seen && c >= "A" && c <= "F") begin
			d = 5'(c - "A" + 8'd10);
		end else begin
			line_err      = ST_NAN;
			line_err_char = c;
			line_phase    = PH_IGNORE;
			return;
		end
		// truncation to the field width gives the wrap
		field_acc = VALUE_WIDTH'(field_acc * (hex_seen ? 16 : 10) + d);
	endfunction

	// Advance the line state by one character; returns 1 when a result is due
	function automatic bit parse_char(input logic [7:0] c, output line_result_t r);
		r = '0;
		if (c == CH_END) begin
			if (line_err != ST_OK) begin
				r.status = line_err;
				if (line_err == ST_NAN)
					r.bad_char = line_err_char;
			end else begin
				case (line_phase)
					PH_LETTER, PH_SEP, PH_FIRST: r.status = ST_USAGE;
					PH_ADDR: r.status = ST_MISSING;
					default: begin
						r.status        = ST_OK;
						r.write_address = addr_hold;
						r.write_data    = field_acc;
					end
				endcase
			end
			clear_line();
			return 1'b1;
		end
		case (line_phase)
			PH_LETTER: line_phase = PH_SEP;
			PH_SEP: begin
				if (c == CH_SPACE) begin
					line_phase = PH_FIRST;
				end else begin
					line_err   = ST_USAGE;
					line_phase = PH_IGNORE;
				end
			end
			PH_FIRST, PH_ADDR: begin
				line_phase = PH_ADDR;
				if (c == CH_SPACE) begin
					addr_hold  = field_acc;
					field_acc  = '0;
					hex_seen   = 1'b0;
					line_phase = PH_VALUE;
				end else begin
					take_digit(c);
				end
			end
			PH_VALUE: begin
				if (c == CH_SPACE)
					line_phase = PH_IGNORE;
				else
					take_digit(c);
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// Fixed line text followed by the terminating zero
	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pending_chars.push_back(s[i]);
		pending_chars.push_back(CH_END);
		lines_sent++;
	endfunction

	// Random number field: decimal, or with an x somewhere and mixed-case hex after it, with an occasional random byte
	function automatic void add_field();
		int len;
		int xpos;
		int k;
		len  = $urandom_range(0, 6);
		xpos = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, len)) : -1;
		for (int i = 0; i <= len; i++) begin
			if (i == xpos)
				line_buf.push_back(CH_X);
			if (i < len) begin
				if ($urandom_range(0, 31) == 0) begin
					line_buf.push_back(8'($urandom_range(1, 255)));
				end else if (xpos >= 0 && i >= xpos) begin
					k = $urandom_range(0, 21);
					if (k < 10)
						line_buf.push_back(8'("0" + k));
					else if (k < 16)
						line_buf.push_back(8'("a" + k - 10));
					else
						line_buf.push_back(8'("A" + k - 16));
				end else begin
					line_buf.push_back(8'("0" + $urandom_range(0, 9)));
				end
			end
		end
	endfunction

	// Mostly well-formed commands, some truncated, some pure noise
	function automatic void add_random_line();
		int kind;
		int cut;
		kind = $urandom_range(0, 9);
		line_buf.delete();
		if (kind == 0) begin
			repeat ($urandom_range(0, 8))
				line_buf.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE
					: 8'($urandom_range(1, 255)));
		end else begin
			line_buf.push_back(8'($urandom_range(1, 255)));
			line_buf.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 255))
				: CH_SPACE);
			add_field();
			line_buf.push_back(CH_SPACE);
			add_field();
			if ($urandom_range(0, 3) == 0) begin
				line_buf.push_back(CH_SPACE);
				repeat ($urandom_range(0, 4))
					line_buf.push_back(8'($urandom_range(1, 255)));
			end
			if (kind == 1) begin
				cut = $urandom_range(0, line_buf.size());
				while (line_buf.size() > cut)
					void'(line_buf.pop_back());
			end
		end
		foreach (line_buf[i])
			pending_chars.push_back(line_buf[i]);
		pending_chars.push_back(CH_END);
		lines_sent++;
	endfunction

	// Character driver with random per-transaction gaps and steady stretches
	int send_wait;
	bit send_steady;

	always @(posedge clk or negedge arst_n) begin
		logic         nxt_valid;
		line_result_t r;
		if (!arst_n) begin
			char_in.valid <= 1'b0;
			char_in.ch    <= '0;
			send_wait   = 0;
			send_steady = 1'b0;
			clear_line();
		end else begin
			nxt_valid = char_in.valid && !char_in.ready;
			if (char_in.valid && char_in.ready) begin
				chars_accepted++;
				if (parse_char(char_in.ch, r))
					expected_results.push_back(r);
			end
			if (!nxt_valid && pending_chars.size() > 0) begin
				if (send_wait == 0) begin
					char_in.ch <= pending_chars.pop_front();
					nxt_valid = 1'b1;
					if ($urandom_range(0, 39) == 0)
						send_steady = !send_steady;
					send_wait = send_steady ? 0 : $urandom_range(0, 15);
				end else begin
					send_wait--;
				end
			end
			char_in.valid <= nxt_valid;
		end
	end

	// Result monitor: ready stalls drawn per transaction, field-by-field compare
	int recv_wait;
	bit recv_steady;

	always @(posedge clk or negedge arst_n) begin
		logic         nxt_ready;
		line_result_t want;
		if (!arst_n) begin
			result_out.ready <= 1'b0;
			recv_wait   = $urandom_range(0, 15);
			recv_steady = 1'b0;
		end else begin
			nxt_ready = result_out.ready;
			if (result_out.valid && result_out.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d address %0h data %0h bad_char %0h",
						result_out.status, result_out.write_address, result_out.write_data,
						result_out.bad_char);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (want.status == ST_OK)
						writes_checked++;
					if (result_out.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status,
							result_out.status);
						error_count++;
					end
					if (result_out.write_address !== want.write_address) begin
						$error("write_address: expected %0h, actual %0h", want.write_address,
							result_out.write_address);
						error_count++;
					end
					if (result_out.write_data !== want.write_data) begin
						$error("write_data: expected %0h, actual %0h", want.write_data,
							result_out.write_data);
						error_count++;
					end
					if (result_out.bad_char !== want.bad_char) begin
						$error("bad_char: expected %0h, actual %0h", want.bad_char,
							result_out.bad_char);
						error_count++;
					end
				end
				nxt_ready = 1'b0;
				if ($urandom_range(0, 39) == 0)
					recv_steady = !recv_steady;
				recv_wait = recv_steady ? 0 : $urandom_range(0, 15);
			end
			if (!nxt_ready) begin
				if (recv_wait == 0)
					nxt_ready = 1'b1;
				else
					recv_wait--;
			end
			result_out.ready <= nxt_ready;
		end
	end

	// Count cycles without any transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (char_in.valid && char_in.ready)
				|| (result_out.valid && result_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("watchdog: %0d cycles without a transaction", IDLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// Stimulus, reset and end of run
	initial begin
		char_in.valid    = 1'b0;
		char_in.ch       = '0;
		result_out.ready = 1'b0;
		arst_n           = 1'b0;

		// empty line, lone letter, bad separator, nothing after the separator
		add_text("");
		add_text("w");
		add_text("wz");
		add_text("w ");
		// top letter code, line ends inside the address
		pending_chars.push_back(8'hFF);
		add_text(" 9");
		// bad character in the address
		add_text("w 1g");
		// empty address, mixed-case hex value, trailing text ignored
		add_text("w  xaB q");
		// decimal address wraps at 16 bits
		add_text("r 70000 9");

		while (pending_chars.size() < CHAR_TARGET)
			add_random_line();

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_chars.size() != 0 || char_in.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d lines in %0d characters; checked %0d results, %0d of them writes",
			lines_sent, chars_accepted, results_checked, writes_checked);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results outstanding", error_count,
				expected_results.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
